[sv/rgbc_pkg.sv]
// ----------------------------------------------------------------------------
// rgbc_pkg: shared types and constants
// Control struct for the channel lanes, result metadata, sequencer states.
// ----------------------------------------------------------------------------
package rgbc_pkg;

	localparam int PIX_W      = 8;
	localparam int PIX_MAX    = 255;
	localparam int TAPS       = 9;
	localparam int TAP_W      = 4;
	localparam int ACC_W      = 20;
	localparam int MAG_W      = 19;
	localparam int DIV_W      = 10;
	localparam int DIV_CNT_W  = 5;
	localparam int DIV_STEPS  = 19;
	localparam int POS_W      = 10;
	localparam int GEOM_W     = 11;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_DIM    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_TOP = 3'd0,
		REG_COEFF_MID = 3'd1,
		REG_COEFF_BOT = 3'd2,
		REG_DIVISOR   = 3'd3,
		REG_WIDTH     = 3'd4,
		REG_HEIGHT    = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic acc_clr;
		logic acc_en;
		logic div_load;
		logic div_en;
	} lane_ctrl_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} res_meta_t;

endpackage

[sv/rgbc_line_store.sv]
// ----------------------------------------------------------------------------
// rgbc_line_store: two-row line store
// One memory word per column holds the older row above the newer row.
// ----------------------------------------------------------------------------
module rgbc_line_store #(
	parameter int DEPTH  = 1024,
	parameter int AW     = 10,
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/rgbc_lane.sv]
// ----------------------------------------------------------------------------
// rgbc_lane: one colour channel
// Multiply-accumulate over the nine taps, then restoring divide and clamp.
// ----------------------------------------------------------------------------
module rgbc_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rgbc_pkg::lane_ctrl_t              ctrl,
	input  logic [rgbc_pkg::PIX_W-1:0]        tap_pix,
	input  logic signed [rgbc_pkg::PIX_W-1:0] tap_coef,
	input  logic [rgbc_pkg::DIV_W-1:0]        divisor,
	output logic [rgbc_pkg::PIX_W-1:0]        result
);

	logic signed [2*rgbc_pkg::PIX_W:0]   prod;
	logic signed [rgbc_pkg::ACC_W-1:0]   acc_q;
	logic [rgbc_pkg::MAG_W-1:0]          mag_q;
	logic [rgbc_pkg::DIV_W-1:0]          rem_q;
	logic                                neg_q;
	logic [rgbc_pkg::DIV_W:0]            trial;
	logic                                fits;
	logic [rgbc_pkg::ACC_W-1:0]          abs_acc;

	assign prod    = $signed({1'b0, tap_pix}) * tap_coef;
	assign trial   = {rem_q, mag_q[rgbc_pkg::MAG_W-1]};
	assign fits    = trial >= {1'b0, divisor};
	assign abs_acc = acc_q[rgbc_pkg::ACC_W-1] ? rgbc_pkg::ACC_W'(-acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + rgbc_pkg::ACC_W'(prod);
		end
	end

	// quotient bits shift into the magnitude register as the dividend leaves it
	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			neg_q <= acc_q[rgbc_pkg::ACC_W-1];
			mag_q <= abs_acc[rgbc_pkg::MAG_W-1:0];
			rem_q <= '0;
		end else if (ctrl.div_en) begin
			rem_q <= fits ? rgbc_pkg::DIV_W'(trial - {1'b0, divisor})
			              : trial[rgbc_pkg::DIV_W-1:0];
			mag_q <= {mag_q[rgbc_pkg::MAG_W-2:0], fits};
		end
	end

	always_comb begin
		if (neg_q) begin
			result = '0;
		end else if (|mag_q[rgbc_pkg::MAG_W-1:rgbc_pkg::PIX_W]) begin
			result = rgbc_pkg::PIX_W'(rgbc_pkg::PIX_MAX);
		end else begin
			result = mag_q[rgbc_pkg::PIX_W-1:0];
		end
	end

endmodule

[sv/rgbc_merge.sv]
// ----------------------------------------------------------------------------
// rgbc_merge: result register
// Joins the three lane results with position metadata into one output beat.
// ----------------------------------------------------------------------------
module rgbc_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	output logic                       load_ready,
	input  logic [rgbc_pkg::PIX_W-1:0] lane_red,
	input  logic [rgbc_pkg::PIX_W-1:0] lane_green,
	input  logic [rgbc_pkg::PIX_W-1:0] lane_blue,
	input  rgbc_pkg::res_meta_t        meta,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rgbc_pkg::PIX_W-1:0] res_red,
	output logic [rgbc_pkg::PIX_W-1:0] res_green,
	output logic [rgbc_pkg::PIX_W-1:0] res_blue,
	output logic [rgbc_pkg::POS_W-1:0] res_row,
	output logic [rgbc_pkg::POS_W-1:0] res_col,
	output logic                       frame_last
);

	logic valid_q;

	assign load_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && load_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ready) begin
			res_red    <= lane_red;
			res_green  <= lane_green;
			res_blue   <= lane_blue;
			res_row    <= meta.row;
			res_col    <= meta.col;
			frame_last <= meta.last;
		end
	end

endmodule

[sv/rgb_convolution_3x3.sv]
// ----------------------------------------------------------------------------
// rgb_convolution_3x3: streaming 3x3 RGB convolution
// Line store and window feed three channel lanes; results leave in raster order.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in, always ready
//  pixel   | in_valid/in_ready, pix_red/green/blue     | in
//  result  | out_valid/out_ready, res_*, frame_last    | out
//
//  A border pixel is accepted and read from the line store only; an interior
//  pixel then also takes nine multiply-accumulate steps, a load, 19 divide steps
//  (one quotient bit each) and a hand-over to the result register, which can stall.
//  The next pixel is taken while a result waits in the output register.
//  Reset clears counters, window, configuration registers and the sequencer; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int KERNEL_DIM = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rgbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rgbc_pkg::PIX_W-1:0]      pix_red,
	input  logic [rgbc_pkg::PIX_W-1:0]      pix_green,
	input  logic [rgbc_pkg::PIX_W-1:0]      pix_blue,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rgbc_pkg::PIX_W-1:0]      res_red,
	output logic [rgbc_pkg::PIX_W-1:0]      res_green,
	output logic [rgbc_pkg::PIX_W-1:0]      res_blue,
	output logic [rgbc_pkg::POS_W-1:0]      res_row,
	output logic [rgbc_pkg::POS_W-1:0]      res_col,
	output logic                            frame_last
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int NWIN   = KERNEL_DIM * KERNEL_DIM;
	localparam int PXW    = 3 * rgbc_pkg::PIX_W;
	localparam int RW     = rgbc_pkg::POS_W;
	localparam int GW     = rgbc_pkg::GEOM_W;

	// configuration
	logic [PXW-1:0]                 coef_q [KERNEL_DIM];
	logic [rgbc_pkg::DIV_W-1:0]     divisor_q;
	logic [GW-1:0]                  width_q;
	logic [GW-1:0]                  height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= '0;
			coef_q[1] <= PXW'(256);
			coef_q[2] <= '0;
			divisor_q <= rgbc_pkg::DIV_W'(1);
			width_q   <= GW'(1024);
			height_q  <= GW'(1024);
		end else if (cfg_valid) begin
			case (cfg_index)
				rgbc_pkg::REG_COEFF_TOP: coef_q[0] <= cfg_data;
				rgbc_pkg::REG_COEFF_MID: coef_q[1] <= cfg_data;
				rgbc_pkg::REG_COEFF_BOT: coef_q[2] <= cfg_data;
				rgbc_pkg::REG_DIVISOR:   divisor_q <= cfg_data[rgbc_pkg::DIV_W-1:0];
				rgbc_pkg::REG_WIDTH:     width_q   <= cfg_data[GW-1:0];
				rgbc_pkg::REG_HEIGHT:    height_q  <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	logic [WW-1:0]              w_eff;
	logic [GW-1:0]              h_eff;
	logic [rgbc_pkg::DIV_W-1:0] d_eff;

	always_comb begin
		if (int'(width_q) < rgbc_pkg::MIN_DIM) begin
			w_eff = WW'(rgbc_pkg::MIN_DIM);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (int'(height_q) < rgbc_pkg::MIN_DIM) begin
			h_eff = GW'(rgbc_pkg::MIN_DIM);
		end else if (int'(height_q) > rgbc_pkg::MAX_HEIGHT) begin
			h_eff = GW'(rgbc_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		d_eff = (divisor_q == '0) ? rgbc_pkg::DIV_W'(1) : divisor_q;
	end

	// position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] c_pre;
	logic [RW:0]   r_bump;
	logic [RW-1:0] r_pre;
	logic [CW:0]   c_inc;
	logic [RW:0]   r_inc;
	logic [CW-1:0] c_nxt;
	logic [RW-1:0] r_nxt;
	logic          pre_wrap;

	always_comb begin
		// a counter left past a narrowed bound wraps as if it had reached it
		pre_wrap = WW'(col_q) >= w_eff;
		c_pre    = pre_wrap ? '0 : col_q;
		r_bump   = {1'b0, row_q} + (RW+1)'(pre_wrap);
		r_pre    = (GW'(r_bump) >= h_eff) ? '0 : r_bump[RW-1:0];
		c_inc    = {1'b0, c_pre} + 1'b1;
		r_inc    = {1'b0, r_pre} + 1'b1;
		if (WW'(c_inc) >= w_eff) begin
			c_nxt = '0;
			r_nxt = (GW'(r_inc) >= h_eff) ? '0 : r_inc[RW-1:0];
		end else begin
			c_nxt = c_inc[CW-1:0];
			r_nxt = r_pre;
		end
	end

	// sequencer
	rgbc_pkg::seq_state_t        state_q, state_d;
	logic [rgbc_pkg::TAP_W-1:0]     tap_q;
	logic [rgbc_pkg::DIV_CNT_W-1:0] div_cnt_q;
	rgbc_pkg::lane_ctrl_t        ctrl;
	logic                        merge_ready;
	logic                        merge_load;
	logic                        in_beat;

	logic [PXW-1:0]       pix_s1;
	logic [CW-1:0]        col_s1;
	logic                 emit_s1;
	rgbc_pkg::res_meta_t  meta_s1;
	logic [2*PXW-1:0]     rd_data;
	logic [PXW-1:0]       win_q [NWIN];

	assign in_ready = (state_q == rgbc_pkg::ST_IDLE);
	assign in_beat  = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		merge_load   = 1'b0;
		case (state_q)
			rgbc_pkg::ST_IDLE: begin
				if (in_valid) state_d = rgbc_pkg::ST_READ;
			end
			rgbc_pkg::ST_READ: begin
				ctrl.acc_clr = 1'b1;
				state_d = emit_s1 ? rgbc_pkg::ST_MAC : rgbc_pkg::ST_IDLE;
			end
			rgbc_pkg::ST_MAC: begin
				ctrl.acc_en = 1'b1;
				if (tap_q == rgbc_pkg::TAP_W'(NWIN - 1)) state_d = rgbc_pkg::ST_LOAD;
			end
			rgbc_pkg::ST_LOAD: begin
				ctrl.div_load = 1'b1;
				state_d = rgbc_pkg::ST_DIV;
			end
			rgbc_pkg::ST_DIV: begin
				ctrl.div_en = 1'b1;
				if (div_cnt_q == rgbc_pkg::DIV_CNT_W'(rgbc_pkg::DIV_STEPS - 1)) begin
					state_d = rgbc_pkg::ST_DONE;
				end
			end
			rgbc_pkg::ST_DONE: begin
				merge_load = 1'b1;
				if (merge_ready) state_d = rgbc_pkg::ST_IDLE;
			end
			default: state_d = rgbc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rgbc_pkg::ST_IDLE;
			tap_q     <= '0;
			div_cnt_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else begin
			state_q <= state_d;
			tap_q     <= (state_q == rgbc_pkg::ST_MAC) ? tap_q + 1'b1 : '0;
			div_cnt_q <= (state_q == rgbc_pkg::ST_DIV) ? div_cnt_q + 1'b1 : '0;
			if (in_beat) begin
				col_q <= c_nxt;
				row_q <= r_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			pix_s1        <= {pix_blue, pix_green, pix_red};
			col_s1        <= c_pre;
			emit_s1       <= (r_pre >= RW'(2)) && (c_pre >= CW'(2));
			meta_s1.row   <= r_pre - 1'b1;
			meta_s1.col   <= RW'(c_pre - 1'b1);
			meta_s1.last  <= (GW'(r_pre) == h_eff - 1'b1) && (WW'(c_pre) == w_eff - 1'b1);
		end
	end

	rgbc_line_store #(
		.DEPTH  (MAX_WIDTH),
		.AW     (CW),
		.DATA_W (2*PXW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_beat),
		.rd_addr (c_pre),
		.rd_data (rd_data),
		.wr_en   (state_q == rgbc_pkg::ST_READ),
		.wr_addr (col_s1),
		.wr_data ({rd_data[PXW-1:0], pix_s1})
	);

	// advance the window one column: older row, newer row, incoming pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NWIN; i++) win_q[i] <= '0;
		end else if (state_q == rgbc_pkg::ST_READ) begin
			for (int i = 0; i < KERNEL_DIM; i++) begin
				for (int j = 0; j < KERNEL_DIM - 1; j++) begin
					win_q[i*KERNEL_DIM + j] <= win_q[i*KERNEL_DIM + j + 1];
				end
			end
			win_q[KERNEL_DIM-1]        <= rd_data[2*PXW-1:PXW];
			win_q[2*KERNEL_DIM-1]      <= rd_data[PXW-1:0];
			win_q[NWIN-1]              <= pix_s1;
		end
	end

	// tap select shared by the lanes
	logic [PXW-1:0]               tap_word;
	logic [PXW-1:0]               coef_row;
	logic signed [rgbc_pkg::PIX_W-1:0] tap_coef;
	logic [rgbc_pkg::TAP_W-1:0]   tap_idx;
	logic [1:0]                   tap_r;
	logic [rgbc_pkg::TAP_W-1:0]   tap_c;

	always_comb begin
		tap_idx  = (tap_q < rgbc_pkg::TAP_W'(NWIN)) ? tap_q : '0;
		tap_word = win_q[tap_idx];
		// split the tap index into kernel row and column by compare and subtract
		tap_r    = '0;
		tap_c    = tap_idx;
		for (int r = 1; r < KERNEL_DIM; r++) begin
			if (tap_idx >= rgbc_pkg::TAP_W'(r * KERNEL_DIM)) begin
				tap_r = 2'(r);
				tap_c = tap_idx - rgbc_pkg::TAP_W'(r * KERNEL_DIM);
			end
		end
		coef_row = coef_q[tap_r];
		tap_coef = coef_row[tap_c * rgbc_pkg::PIX_W +: rgbc_pkg::PIX_W];
	end

	logic [rgbc_pkg::PIX_W-1:0] lane_res [3];

	for (genvar g = 0; g < 3; g++) begin : g_lane
		rgbc_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.tap_pix  (tap_word[g*rgbc_pkg::PIX_W +: rgbc_pkg::PIX_W]),
			.tap_coef (tap_coef),
			.divisor  (d_eff),
			.result   (lane_res[g])
		);
	end

	rgbc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (merge_load),
		.load_ready (merge_ready),
		.lane_red   (lane_res[0]),
		.lane_green (lane_res[1]),
		.lane_blue  (lane_res[2]),
		.meta       (meta_s1),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res_red    (res_red),
		.res_green  (res_green),
		.res_blue   (res_blue),
		.res_row    (res_row),
		.res_col    (res_col),
		.frame_last (frame_last)
	);

	a_beat_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q == rgbc_pkg::ST_READ)
		else $error("accepted beat did not start a line store read");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rgbc_pkg::ST_DIV |-> div_cnt_q < rgbc_pkg::DIV_CNT_W'(rgbc_pkg::DIV_STEPS))
		else $error("divide step count overran");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgbc_pkg::ST_DONE && !merge_ready) |=> state_q == rgbc_pkg::ST_DONE)
		else $error("finished result dropped while output stalled");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == rgbc_pkg::ST_DONE)
		else $error("result beat appeared without a finished item");

endmodule
